@@ sv/laq_pkg.sv @@
package laq_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned IDX_W  = $clog2(DEPTH + 1);
  localparam int unsigned CAP_W  = 7;
  localparam int unsigned CMP_W  = (IDX_W > CAP_W) ? IDX_W : CAP_W;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [1:0] {
    F_INSERT  = 2'd0,
    F_DELETE  = 2'd1,
    F_DISPLAY = 2'd2,
    F_UPDATE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOMATCH  = 2'd3
  } status_e;

endpackage

@@ sv/laq_in_if.sv @@
interface laq_in_if;
  logic                                valid;
  logic                                ready;
  laq_pkg::func_e                      func;
  logic signed [laq_pkg::DATA_W-1:0]   value;
  logic signed [laq_pkg::DATA_W-1:0]   key;

  modport source (output valid, func, value, key, input ready);
  modport sink   (input valid, func, value, key, output ready);
endinterface

@@ sv/laq_out_if.sv @@
interface laq_out_if;
  logic                                valid;
  logic                                ready;
  laq_pkg::status_e                    status;
  logic signed [laq_pkg::DATA_W-1:0]   data;
  logic        [laq_pkg::CNT_W-1:0]    match_count;
  logic                                last;

  modport source (output valid, status, data, match_count, last, input ready);
  modport sink   (input valid, status, data, match_count, last, output ready);
endinterface

@@ sv/linear_array_queue_search_update_unit.sv @@
// Insert and empty-queue results are registered on acceptance; delete reads the head entry
// first; display gives one beat per stored entry; update walks all entries, then answers.
// Throughput: one operation at a time; the entry walk of display and update is bound by
// the single read port of the entry memory, one entry per cycle unless display is stalled.
// Reset clears head, tail and the output valid flag and sets capacity to 64; entry
// contents stay undefined until written.
module linear_array_queue_search_update_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  laq_in_if.sink                        item_i,
  laq_out_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [laq_pkg::PADDR_W-1:0]   paddr,
  input  logic [laq_pkg::PDATA_W-1:0]   pwdata,
  output logic [laq_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import laq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEL  = 5'b00010,
    S_DISP = 5'b00100,
    S_UPD  = 5'b01000,
    S_UEND = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [IDX_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [ADDR_W-1:0] ridx_q, ridx_d;
  logic [IDX_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] key_q, key_d, val_q, val_d;
  logic [CAP_W-1:0]  cap_q;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;
  logic              out_last_q, out_last_d;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;

  logic              out_free, accept, empty, overflow, ridx_last;
  logic [CMP_W-1:0]  cap_w;
  logic [IDX_W-1:0]  head_inc;

  // Configuration port: one register, every address decodes to it
  assign pready = 1'b1;
  assign prdata = PDATA_W'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_free  = !out_valid_q || res_o.ready;
  assign item_i.ready = (state_q == S_IDLE) && out_free;
  assign accept    = item_i.valid && item_i.ready;
  assign empty     = (head_q == tail_q);
  assign cap_w     = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);
  assign overflow  = (CMP_W'(tail_q) >= cap_w);
  assign ridx_last = ((IDX_W'(ridx_q) + IDX_W'(1)) == tail_q);
  assign head_inc  = head_q + IDX_W'(1);

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    ridx_d       = ridx_q;
    count_d      = count_q;
    key_d        = key_q;
    val_d        = val_q;
    out_valid_d  = out_valid_q && !res_o.ready;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_count_d  = out_count_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          // single-beat results default to zero data and count
          out_data_d  = '0;
          out_count_d = '0;
          out_last_d  = 1'b1;
          if (item_i.func == F_INSERT) begin
            out_valid_d = 1'b1;
            if (overflow) begin
              out_status_d = ST_OVERFLOW;
            end else begin
              mem_we       = 1'b1;
              mem_waddr    = tail_q[ADDR_W-1:0];
              mem_wdata    = item_i.value;
              tail_d       = tail_q + IDX_W'(1);
              out_status_d = ST_OK;
            end
          end else if (empty) begin
            out_valid_d  = 1'b1;
            out_status_d = ST_EMPTY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = head_q[ADDR_W-1:0];
            ridx_d    = head_q[ADDR_W-1:0];
            unique case (item_i.func)
              F_DELETE:  state_d = S_DEL;
              F_DISPLAY: state_d = S_DISP;
              F_UPDATE: begin
                key_d   = item_i.key;
                val_d   = item_i.value;
                count_d = '0;
                state_d = S_UPD;
              end
              default: state_d = S_IDLE;
            endcase
          end
        end
      end

      S_DEL: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_data_d   = rdata_q;
          out_count_d  = '0;
          out_last_d   = 1'b1;
          // drop back to an empty array once the last entry leaves
          if (head_inc >= tail_q) begin
            head_d = '0;
            tail_d = '0;
          end else begin
            head_d = head_inc;
          end
          state_d = S_IDLE;
        end
      end

      S_DISP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_data_d   = rdata_q;
          out_count_d  = '0;
          out_last_d   = ridx_last;
          if (ridx_last) begin
            state_d = S_IDLE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ridx_q + ADDR_W'(1);
            ridx_d    = ridx_q + ADDR_W'(1);
          end
        end
      end

      S_UPD: begin
        // compare the entry read last cycle, write back on a match
        if (rdata_q == key_q) begin
          mem_we    = 1'b1;
          mem_waddr = ridx_q;
          mem_wdata = val_q;
          count_d   = count_q + IDX_W'(1);
        end
        if (ridx_last) begin
          state_d = S_UEND;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ridx_q + ADDR_W'(1);
          ridx_d    = ridx_q + ADDR_W'(1);
        end
      end

      S_UEND: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = (count_q == '0) ? ST_NOMATCH : ST_OK;
          out_data_d   = '0;
          out_count_d  = CNT_W'(count_q);
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q       <= ridx_d;
    count_q      <= count_d;
    key_q        <= key_d;
    val_q        <= val_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_count_q  <= out_count_d;
    out_last_q   <= out_last_d;
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_status_q;
  assign res_o.data        = out_data_q;
  assign res_o.match_count = out_count_q;
  assign res_o.last        = out_last_q;

endmodule

@@ sv/laq_chk.sv @@
module laq_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input laq_pkg::func_e                in_func_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input laq_pkg::status_e              out_status_i,
  input logic [laq_pkg::DATA_W-1:0]    out_data_i,
  input logic [laq_pkg::CNT_W-1:0]     out_count_i,
  input logic                          out_last_i,
  input logic                          psel_i,
  input logic                          penable_i,
  input logic                          pwrite_i,
  input logic [laq_pkg::PDATA_W-1:0]   pwdata_i,
  input logic [laq_pkg::PDATA_W-1:0]   prdata_i
);
  import laq_pkg::*;

  // hold the beat while the sink stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i)
      && $stable(out_status_i) && $stable(out_last_i))
    else $error("result beat changed while stalled");

  // a new item is never taken over a stalled result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("item accepted over a stalled result");

  // an insert answers with a single beat in the next cycle
  a_insert_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_func_i == F_INSERT |=>
      out_valid_i && out_last_i && out_data_i == '0 && out_count_i == '0
      && (out_status_i == ST_OK || out_status_i == ST_OVERFLOW))
    else $error("insert result missing or malformed");

  // only display emits beats that are not last, and those are plain ok beats
  a_mid_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_status_i == ST_OK && out_count_i == '0)
    else $error("non-final beat with bad status or count");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel_i && penable_i && pwrite_i |=>
      prdata_i[CAP_W-1:0] == $past(pwdata_i[CAP_W-1:0]))
    else $error("capacity readback mismatch");

endmodule

bind linear_array_queue_search_update_unit laq_chk u_laq_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (item_i.valid),
  .in_ready_i   (item_i.ready),
  .in_func_i    (item_i.func),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .out_status_i (res_o.status),
  .out_data_i   (res_o.data),
  .out_count_i  (res_o.match_count),
  .out_last_i   (res_o.last),
  .psel_i       (psel),
  .penable_i    (penable),
  .pwrite_i     (pwrite),
  .pwdata_i     (pwdata),
  .prdata_i     (prdata)
);
